FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on the rising edge of clk, off during reset.
`define OWDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on the rising edge of clk, off during reset.
`define OWDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/owdm_pkg.sv
package owdm_pkg;

    localparam int SPEED_FRAC_BITS = 10;

    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DIV_W   = 64;
    localparam int DIV_Q_W = 31;

    localparam int SQRT_W  = 64;
    localparam int ROOT_W  = SQRT_W / 2;

    localparam int UNIT_SHIFT = 46;

    localparam logic [MUL_B_W-1:0] MIX_HALF = MUL_B_W'(500000);
    localparam logic [MUL_B_W-1:0] MIX_SIN  = MUL_B_W'(866025);

    localparam logic [DIV_W-1:0] SCALE_DIV   = DIV_W'(10000000);
    localparam logic [DIV_W-1:0] SCALE_ROUND = DIV_W'(5000000);

endpackage

FILE: rtl/omni_wheel_drive_mixer.sv
// An accepted input beat runs through the arithmetic states to its output beat; a zero
// heading skips the square root, unit division and rotation, and follow mode with no
// position skips all arithmetic. The bit-serial square root, dividers and multipliers
// (32, 31 and 16 steps) set the time taken. One item is worked on at a time, so a new
// beat is taken only once the last result is loaded, which waits while the output stalls.
// Reset is asynchronous and active low; it clears the sequencer, the send counter
// and the last command, and sets joystick_mode to 0 and send_gap to 2.
`include "assert_macros.svh"

module omni_wheel_drive_mixer
    import owdm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // stick_x, stick_y, heading_x, heading_y, robot_x, robot_y, view_x, view_y
    input  logic [127:0] s_tdata,
    // position_valid
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // wheel_a, wheel_b, wheel_c
    output logic [95:0]  m_tdata,
    // new_command
    output logic         m_tuser,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [3:0]   cfg_data
);

    localparam logic [0:0] CFG_JOYSTICK_MODE = 1'b0;
    localparam logic [0:0] CFG_SEND_GAP      = 1'b1;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_NORM   = 12'b000000000010,
        ST_SQRT   = 12'b000000000100,
        ST_UDIV   = 12'b000000001000,
        ST_ROT1   = 12'b000000010000,
        ST_ROT2   = 12'b000000100000,
        ST_TENTH  = 12'b000001000000,
        ST_MIX    = 12'b000010000000,
        ST_SCALE1 = 12'b000100000000,
        ST_SCALE2 = 12'b001000000000,
        ST_SEND   = 12'b010000000000,
        ST_OUT    = 12'b100000000000
    } state_t;

    function automatic logic [49:0] sgn50(input logic [MUL_P_W-1:0] mag, input logic neg);
        logic [49:0] ext;
        ext = 50'(mag);
        return neg ? (~ext + 50'd1) : ext;
    endfunction

    function automatic logic [15:0] tenths(input logic [49:0] v, input logic joy);
        logic [49:0] mag;
        logic [63:0] sum;
        mag = v[49] ? (~v + 50'd1) : v;
        sum = (64'(mag) << 3) + (64'(mag) << 1)
            + (joy ? (64'd1 << 43) : (64'd1 << 33));
        return joy ? sum[59:44] : sum[49:34];
    endfunction

    function automatic logic [38:0] mag39(input logic [39:0] v);
        logic [39:0] t;
        t = v[39] ? (~v + 40'd1) : v;
        return t[38:0];
    endfunction

    function automatic logic [DIV_W-1:0] scale_num(input logic [38:0] mag, input logic joy);
        logic [DIV_W-1:0] m;
        m = DIV_W'(mag) << SPEED_FRAC_BITS;
        if (joy)
        begin
            m = m << 1;
        end
        return m + SCALE_ROUND;
    endfunction

    function automatic logic [31:0] wheel(input logic [DIV_Q_W-1:0] q, input logic neg);
        logic [31:0] ext;
        ext = 32'(q);
        return neg ? (~ext + 32'd1) : ext;
    endfunction

    state_t state_reg, state_next;
    logic   launch_reg, launch_next;
    logic   mode_reg, mode_next;
    logic [3:0] gap_reg, gap_next;
    logic   joy_reg, joy_next;
    logic   skip_reg, skip_next;

    logic [15:0] hx_reg, hx_next, hy_reg, hy_next;
    logic [16:0] mx_reg, mx_next, my_reg, my_next;
    logic [31:0] n_reg, n_next;
    logic [ROOT_W-1:0]  r_reg, r_next;
    logic [DIV_Q_W-1:0] ux_reg, ux_next, uy_reg, uy_next;
    logic [49:0] rx_reg, rx_next, ry_reg, ry_next;
    logic        vxn_reg, vxn_next, vyn_reg, vyn_next;
    logic [15:0] vxm_reg, vxm_next, vym_reg, vym_next;
    logic        na_reg, na_next, nb_reg, nb_next, nc_reg, nc_next;
    logic [38:0] ma_reg, ma_next, mb_reg, mb_next, mc_reg, mc_next;
    logic [31:0] wa_reg, wa_next, wb_reg, wb_next, wc_reg, wc_next;

    logic [4:0]  cnt_reg, cnt_next;
    logic        sent_reg, sent_next;
    logic [31:0] last_a_reg, last_a_next, last_b_reg, last_b_next;
    logic [31:0] last_c_reg, last_c_next;
    logic        new_cmd_next;
    logic        cmd_reg, cmd_next;

    logic        out_valid_reg, out_valid_next;
    logic [95:0] out_data_reg, out_data_next;
    logic        out_cmd_reg, out_cmd_next;

    logic                 mul_start, div_start, sqrt_start;
    logic [MUL_A_W-1:0]   mul0_a, mul1_a;
    logic [MUL_B_W-1:0]   mul0_b, mul1_b;
    logic [MUL_P_W-1:0]   mul0_p, mul1_p;
    logic                 mul0_busy, mul1_busy;
    logic [DIV_W-1:0]     div0_n, div1_n, div0_d, div1_d;
    logic [DIV_Q_W-1:0]   div0_q, div1_q;
    logic                 div0_busy, div1_busy;
    logic [ROOT_W-1:0]    root;
    logic                 sqrt_busy;
    logic                 unit_busy, advance;

    logic [15:0] hx_mag, hy_mag, mx_mag, my_mag;
    logic [16:0] mx_inv, my_inv;
    logic        hx_neg, hy_neg, mx_neg, my_neg;

    assign hx_neg = hx_reg[15];
    assign hy_neg = hy_reg[15];
    assign mx_neg = mx_reg[16];
    assign my_neg = my_reg[16];
    assign hx_mag = hx_neg ? (~hx_reg + 16'd1) : hx_reg;
    assign hy_mag = hy_neg ? (~hy_reg + 16'd1) : hy_reg;
    assign mx_inv = ~mx_reg + 17'd1;
    assign my_inv = ~my_reg + 17'd1;
    assign mx_mag = mx_neg ? mx_inv[15:0] : mx_reg[15:0];
    assign my_mag = my_neg ? my_inv[15:0] : my_reg[15:0];

    assign unit_busy = mul0_busy | mul1_busy | div0_busy | div1_busy | sqrt_busy;
    assign advance   = !launch_reg && !unit_busy;

    assign mul_start  = launch_reg && ((state_reg == ST_NORM) || (state_reg == ST_ROT1)
                        || (state_reg == ST_ROT2) || (state_reg == ST_MIX));
    assign div_start  = launch_reg && ((state_reg == ST_UDIV) || (state_reg == ST_SCALE1)
                        || (state_reg == ST_SCALE2));
    assign sqrt_start = launch_reg && (state_reg == ST_SQRT);

    always_comb
    begin
        case (state_reg)
            ST_NORM:
            begin
                mul0_a = hx_mag;
                mul0_b = 32'(hx_mag);
                mul1_a = hy_mag;
                mul1_b = 32'(hy_mag);
            end
            ST_ROT1:
            begin
                mul0_a = mx_mag;
                mul0_b = 32'(uy_reg);
                mul1_a = my_mag;
                mul1_b = 32'(ux_reg);
            end
            ST_ROT2:
            begin
                mul0_a = mx_mag;
                mul0_b = 32'(ux_reg);
                mul1_a = my_mag;
                mul1_b = 32'(uy_reg);
            end
            default:
            begin
                mul0_a = vxm_reg;
                mul0_b = MIX_HALF;
                mul1_a = vym_reg;
                mul1_b = MIX_SIN;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_UDIV:
            begin
                div0_n = DIV_W'(hx_mag) << UNIT_SHIFT;
                div1_n = DIV_W'(hy_mag) << UNIT_SHIFT;
                div0_d = DIV_W'(r_reg);
                div1_d = DIV_W'(r_reg);
            end
            ST_SCALE1:
            begin
                div0_n = scale_num(ma_reg, joy_reg);
                div1_n = scale_num(mb_reg, joy_reg);
                div0_d = SCALE_DIV;
                div1_d = SCALE_DIV;
            end
            default:
            begin
                div0_n = scale_num(mc_reg, joy_reg);
                div1_n = scale_num(mc_reg, joy_reg);
                div0_d = SCALE_DIV;
                div1_d = SCALE_DIV;
            end
        endcase
    end

    owdm_mul u_mul0 (.clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul0_a), .b(mul0_b),
                     .busy(mul0_busy), .prod(mul0_p));
    owdm_mul u_mul1 (.clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul1_a), .b(mul1_b),
                     .busy(mul1_busy), .prod(mul1_p));
    owdm_div u_div0 (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div0_n),
                     .den(div0_d), .busy(div0_busy), .quot(div0_q));
    owdm_div u_div1 (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div1_n),
                     .den(div1_d), .busy(div1_busy), .quot(div1_q));
    owdm_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sqrt_start), .val({n_reg, 32'd0}),
                      .busy(sqrt_busy), .root(root));

    logic [31:0] n_sum;
    logic [39:0] s1, s2, e1, e2, sum_a, sum_b, sum_c;
    logic [4:0]  cnt_inc;
    logic        differ;

    assign n_sum   = mul0_p[31:0] + mul1_p[31:0];
    assign e1      = mul0_p[39:0];
    assign e2      = mul1_p[39:0];
    assign s1      = vxn_reg ? (~e1 + 40'd1) : e1;
    assign s2      = vyn_reg ? (~e2 + 40'd1) : e2;
    assign sum_a   = {s1[38:0], 1'b0};
    assign sum_b   = s2 - s1;
    assign sum_c   = ~(s1 + s2) + 40'd1;
    assign cnt_inc = (cnt_reg != 5'd31) ? cnt_reg + 5'd1 : cnt_reg;
    assign differ  = (wa_reg != last_a_reg) || (wb_reg != last_b_reg)
                     || (wc_reg != last_c_reg);

    always_comb
    begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        mode_next      = mode_reg;
        gap_next       = gap_reg;
        joy_next       = joy_reg;
        skip_next      = skip_reg;
        hx_next        = hx_reg;
        hy_next        = hy_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        n_next         = n_reg;
        r_next         = r_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        vxn_next       = vxn_reg;
        vyn_next       = vyn_reg;
        vxm_next       = vxm_reg;
        vym_next       = vym_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        nc_next        = nc_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        mc_next        = mc_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        wc_next        = wc_reg;
        cnt_next       = cnt_reg;
        sent_next      = sent_reg;
        last_a_next    = last_a_reg;
        last_b_next    = last_b_reg;
        last_c_next    = last_c_reg;
        new_cmd_next   = 1'b0;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_cmd_next   = out_cmd_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_JOYSTICK_MODE: mode_next = cfg_data[0];
                CFG_SEND_GAP:      gap_next  = cfg_data;
                default:           mode_next = mode_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    joy_next  = mode_reg;
                    skip_next = !mode_reg && !s_tuser;
                    hx_next   = s_tdata[47:32];
                    hy_next   = s_tdata[63:48];
                    if (mode_reg)
                    begin
                        mx_next = {s_tdata[15], s_tdata[15:0]};
                        my_next = {s_tdata[31], s_tdata[31:16]};
                    end
                    else
                    begin
                        mx_next = {1'b0, s_tdata[79:64]} - {1'b0, s_tdata[111:96]};
                        my_next = {1'b0, s_tdata[95:80]} - {1'b0, s_tdata[127:112]};
                    end
                    if (!mode_reg && !s_tuser)
                    begin
                        wa_next    = '0;
                        wb_next    = '0;
                        wc_next    = '0;
                        state_next = ST_SEND;
                    end
                    else
                    begin
                        state_next  = ST_NORM;
                        launch_next = 1'b1;
                    end
                end
            end
            ST_NORM:
            begin
                if (advance)
                begin
                    launch_next = 1'b1;
                    if (n_sum == 32'd0)
                    begin
                        vxn_next   = 1'b0;
                        vyn_next   = 1'b0;
                        vxm_next   = '0;
                        vym_next   = '0;
                        state_next = ST_MIX;
                    end
                    else
                    begin
                        n_next     = n_sum;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                if (advance)
                begin
                    r_next      = root;
                    launch_next = 1'b1;
                    state_next  = ST_UDIV;
                end
            end
            ST_UDIV:
            begin
                if (advance)
                begin
                    ux_next     = div0_q;
                    uy_next     = div1_q;
                    launch_next = 1'b1;
                    state_next  = ST_ROT1;
                end
            end
            ST_ROT1:
            begin
                if (advance)
                begin
                    rx_next     = sgn50(mul1_p, my_neg ^ hx_neg)
                                  - sgn50(mul0_p, mx_neg ^ hy_neg);
                    launch_next = 1'b1;
                    state_next  = ST_ROT2;
                end
            end
            ST_ROT2:
            begin
                if (advance)
                begin
                    ry_next    = ~(sgn50(mul0_p, mx_neg ^ hx_neg)
                                   + sgn50(mul1_p, my_neg ^ hy_neg)) + 50'd1;
                    state_next = ST_TENTH;
                end
            end
            ST_TENTH:
            begin
                vxm_next    = tenths(rx_reg, joy_reg);
                vym_next    = tenths(ry_reg, joy_reg);
                vxn_next    = joy_reg ? rx_reg[49] : !rx_reg[49];
                vyn_next    = joy_reg ? !ry_reg[49] : ry_reg[49];
                launch_next = 1'b1;
                state_next  = ST_MIX;
            end
            ST_MIX:
            begin
                if (advance)
                begin
                    na_next     = sum_a[39];
                    nb_next     = sum_b[39];
                    nc_next     = sum_c[39];
                    ma_next     = mag39(sum_a);
                    mb_next     = mag39(sum_b);
                    mc_next     = mag39(sum_c);
                    launch_next = 1'b1;
                    state_next  = ST_SCALE1;
                end
            end
            ST_SCALE1:
            begin
                if (advance)
                begin
                    wa_next     = wheel(div0_q, na_reg);
                    wb_next     = wheel(div1_q, nb_reg);
                    launch_next = 1'b1;
                    state_next  = ST_SCALE2;
                end
            end
            ST_SCALE2:
            begin
                if (advance)
                begin
                    wc_next    = wheel(div0_q, nc_reg);
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (!skip_reg)
                begin
                    cnt_next = cnt_inc;
                    if ((cnt_inc > {1'b0, gap_reg}) && (!sent_reg || differ))
                    begin
                        new_cmd_next = 1'b1;
                        cnt_next     = 5'd0;
                        sent_next    = 1'b1;
                        last_a_next  = wa_reg;
                        last_b_next  = wb_reg;
                        last_c_next  = wc_reg;
                    end
                end
                cmd_next   = new_cmd_next;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {wc_reg, wb_reg, wa_reg};
                    out_cmd_next   = cmd_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            mode_reg      <= 1'b0;
            gap_reg       <= 4'd2;
            cnt_reg       <= '0;
            sent_reg      <= 1'b0;
            last_a_reg    <= '0;
            last_b_reg    <= '0;
            last_c_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            mode_reg      <= mode_next;
            gap_reg       <= gap_next;
            cnt_reg       <= cnt_next;
            sent_reg      <= sent_next;
            last_a_reg    <= last_a_next;
            last_b_reg    <= last_b_next;
            last_c_reg    <= last_c_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        joy_reg      <= joy_next;
        skip_reg     <= skip_next;
        hx_reg       <= hx_next;
        hy_reg       <= hy_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        n_reg        <= n_next;
        r_reg        <= r_next;
        ux_reg       <= ux_next;
        uy_reg       <= uy_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        vxn_reg      <= vxn_next;
        vyn_reg      <= vyn_next;
        vxm_reg      <= vxm_next;
        vym_reg      <= vym_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        nc_reg       <= nc_next;
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        mc_reg       <= mc_next;
        wa_reg       <= wa_next;
        wb_reg       <= wb_next;
        wc_reg       <= wc_next;
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
        out_cmd_reg  <= out_cmd_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_cmd_reg;

    `OWDM_ASSERT_NEXT(a_cnt_restart, (state_reg == ST_SEND) && new_cmd_next, cnt_reg == 5'd0, "send counter did not restart after a new command")
    `OWDM_ASSERT_NEXT(a_sent_sticky, sent_reg, sent_reg, "sent flag cleared outside reset")
    `OWDM_ASSERT_NEXT(a_out_hold, (state_reg == ST_OUT) && m_tvalid && !m_tready, state_reg == ST_OUT, "result left while output beat was stalled")
    `OWDM_ASSERT_NOW(a_idle_quiet, s_tready, !unit_busy, "arithmetic unit busy while idle")

endmodule

FILE: rtl/owdm_mul.sv
module owdm_mul
    import owdm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               busy,
    output logic [MUL_P_W-1:0] prod
);

    localparam int CNT_W = $clog2(MUL_A_W + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_P_W-1:0] b_reg, b_next;
    logic [MUL_P_W-1:0] acc_reg, acc_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        if (start)
        begin
            cnt_next = CNT_W'(MUL_A_W);
            a_next   = a;
            b_next   = MUL_P_W'(b);
            acc_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            a_next   = a_reg >> 1;
            b_next   = b_reg << 1;
            acc_next = a_reg[0] ? acc_reg + b_reg : acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;

endmodule

FILE: rtl/owdm_div.sv
module owdm_div
    import owdm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_W-1:0]   num,
    input  logic [DIV_W-1:0]   den,
    output logic               busy,
    output logic [DIV_Q_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   dsh_reg, dsh_next;
    logic [DIV_Q_W-1:0] q_reg, q_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIV_Q_W);
            rem_next = num;
            dsh_next = den << (DIV_Q_W - 1);
            q_next   = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            dsh_next = dsh_reg >> 1;
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                q_next   = {q_reg[DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;

endmodule

FILE: rtl/owdm_sqrt.sv
module owdm_sqrt
    import owdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQRT_W-1:0] val,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SQRT_W-1:0] v_reg, v_next;
    logic [SQRT_W-1:0] r_reg, r_next;
    logic [SQRT_W-1:0] bit_reg, bit_next;
    logic [SQRT_W-1:0] trial;

    assign trial = r_reg + bit_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        v_next   = v_reg;
        r_next   = r_reg;
        bit_next = bit_reg;
        if (start)
        begin
            cnt_next = CNT_W'(ROOT_W);
            v_next   = val;
            r_next   = '0;
            bit_next = SQRT_W'(1) << (SQRT_W - 2);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            bit_next = bit_reg >> 2;
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign busy = (cnt_reg != '0);
    assign root = r_reg[ROOT_W-1:0];

endmodule
